// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared codes and types of the marker sequence checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

  localparam int CODE_W   = 32;
  localparam int ENTRY_W  = 9;
  localparam int SLOT_W   = 8;
  localparam int REASON_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] MODE_CHECK   = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [1:0] DIR_FORWARD  = 2'b01;

  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 1'd1;

  localparam logic [REASON_W-1:0] RSN_DISABLED    = 4'd0;
  localparam logic [REASON_W-1:0] RSN_SAME        = 4'd1;
  localparam logic [REASON_W-1:0] RSN_FIRST_HEAD  = 4'd2;
  localparam logic [REASON_W-1:0] RSN_FIRST_OTHER = 4'd3;
  localparam logic [REASON_W-1:0] RSN_FORWARD     = 4'd4;
  localparam logic [REASON_W-1:0] RSN_FORWARD_OUT = 4'd5;
  localparam logic [REASON_W-1:0] RSN_RETREAT     = 4'd6;
  localparam logic [REASON_W-1:0] RSN_OUT_ORDER   = 4'd7;
  localparam logic [REASON_W-1:0] RSN_ACK         = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  typedef struct packed {
    logic code_found;
    logic code_head;
    logic before_hit;
    logic after_hit;
  } probe_t;

endpackage

`default_nettype wire

// ===== rtl/msc_if.sv =====
// ----------------------------------------------------------------------------
// msc interfaces
// Item, result and register write channels with valid/ready transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msc_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [31:0]       code;
  logic signed [1:0] direction;
  logic [7:0]        entry_index;
  logic              column_start;

  modport source (output valid, mode, code, direction, entry_index, column_start,
                  input ready);
  modport sink   (input valid, mode, code, direction, entry_index, column_start,
                  output ready);
endinterface

interface msc_result_if;
  logic       valid;
  logic       ready;
  logic       in_order;
  logic [3:0] reason;

  modport source (output valid, in_order, reason, input ready);
  modport sink   (input valid, in_order, reason, output ready);
endinterface

interface msc_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/msc_cell.sv =====
// ----------------------------------------------------------------------------
// msc_cell
// One table slot of the ring: holds a code and its head flag, loads on a
// table write and takes its neighbor's contents on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msc_cell (
  input  wire logic                      clk_i,
  input  wire logic                      shift_i,
  input  wire logic [msc_pkg::CODE_W-1:0] nxt_code_i,
  input  wire logic                      nxt_head_i,
  input  wire logic                      wr_i,
  input  wire logic [msc_pkg::CODE_W-1:0] wr_code_i,
  input  wire logic                      wr_head_i,
  output logic      [msc_pkg::CODE_W-1:0] code_o,
  output logic                           head_o
);
  import msc_pkg::*;

  logic [CODE_W-1:0] code_q;
  logic              head_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      code_q <= wr_code_i;
      head_q <= wr_head_i;
    end else if (shift_i) begin
      code_q <= nxt_code_i;
      head_q <= nxt_head_i;
    end
  end

  assign code_o = code_q;
  assign head_o = head_q;

endmodule

`default_nettype wire

// ===== rtl/msc_probe.sv =====
// ----------------------------------------------------------------------------
// msc_probe
// Watches the slot at the ring output during a scan: finds the first slot
// of the new code and of the last code, and checks the last code's column
// neighbors against the new code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msc_probe (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       step_i,
  input  wire logic                       first_i,
  input  wire logic [msc_pkg::CODE_W-1:0] entry_code_i,
  input  wire logic                       entry_head_i,
  input  wire logic [msc_pkg::CODE_W-1:0] code_i,
  input  wire logic [msc_pkg::CODE_W-1:0] prev_i,
  output msc_pkg::probe_t                 probe_o
);
  import msc_pkg::*;

  probe_t            probe_q;
  logic              prev_found_q;
  logic              pend_after_q;
  logic [CODE_W-1:0] last_entry_q;

  logic code_eq;
  logic prev_eq;
  logic last_eq;

  assign code_eq = (entry_code_i == code_i);
  assign prev_eq = (entry_code_i == prev_i);
  assign last_eq = (last_entry_q == code_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q      <= '0;
      prev_found_q <= 1'b0;
      pend_after_q <= 1'b0;
    end else if (start_i) begin
      probe_q      <= '0;
      prev_found_q <= 1'b0;
      pend_after_q <= 1'b0;
    end else if (step_i) begin
      if (!probe_q.code_found && code_eq) begin
        probe_q.code_found <= 1'b1;
        probe_q.code_head  <= entry_head_i;
      end
      if (!prev_found_q && prev_eq) begin
        prev_found_q       <= 1'b1;
        pend_after_q       <= 1'b1;
        probe_q.before_hit <= !first_i && !entry_head_i && last_eq;
      end else if (pend_after_q) begin
        pend_after_q      <= 1'b0;
        probe_q.after_hit <= !entry_head_i && code_eq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      last_entry_q <= entry_code_i;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

// ===== rtl/marker_sequence_checker.sv =====
// ----------------------------------------------------------------------------
// marker_sequence_checker
// Checks the order of floor marker codes against a loaded column table held
// in a ring of cells that rotates past a single compare probe.
// ----------------------------------------------------------------------------
//  channel   dir  transfer when         carries
//  item_i    in   valid & ready         mode, code, direction, entry_index,
//                                       column_start
//  result_o  out  valid & ready         in_order, reason
//  cfg_i     in   valid & ready         index, data (always ready)
//
//  A check that needs the table scans it: the ring makes one full turn, one
//  slot per cycle, past the probe. Loads, restarts and trivial checks skip
//  the scan.
//  item_i is ready whenever no item is in work; a result held by a stalled
//  result_o does not block the next item's transfer.
//  Reset clears the last code and the entry count and enables checking; table contents stay unknown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module marker_sequence_checker #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  msc_item_if.sink     item_i,
  msc_result_if.source result_o,
  msc_cfg_if.sink      cfg_i
);
  import msc_pkg::*;

  localparam int CW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMPW = ((CW > ENTRY_W) ? CW : ENTRY_W) + 1;

  state_e state_q, state_d;

  logic               check_en_q;
  logic [ENTRY_W-1:0] entries_q;
  logic [CODE_W-1:0]  prev_q;
  logic [CODE_W-1:0]  item_code_q;
  logic [1:0]         item_dir_q;
  logic               from_scan_q;
  logic               pend_ok_q;
  logic [REASON_W-1:0] pend_reason_q;
  logic [CW-1:0]      step_q;
  logic               out_valid_q;
  logic               out_ok_q;
  logic [REASON_W-1:0] out_reason_q;

  logic in_xfer;
  logic out_free;
  logic shift;
  logic step_active;
  logic scan_last;
  logic start_scan;

  logic [CODE_W-1:0] cell_code [TABLE_DEPTH];
  logic              cell_head [TABLE_DEPTH];

  probe_t probe;

  logic                dec_ok;
  logic [REASON_W-1:0] dec_reason;
  logic [CODE_W-1:0]   dec_prev;

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_xfer      = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign shift        = (state_q == ST_SCAN);
  assign step_active  = shift && (CMPW'(step_q) < CMPW'(entries_q));
  assign scan_last    = (step_q == CW'(TABLE_DEPTH - 1));
  assign start_scan   = in_xfer && (item_i.mode == MODE_CHECK) && check_en_q &&
                        (item_i.code != prev_q);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q <= 1'b1;
      entries_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CHECK_ENABLED:  check_en_q <= cfg_i.data[0];
        REG_ENTRIES_IN_USE: entries_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ring: slot k takes slot k+1, the last slot takes slot 0
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic wr;
    assign wr = in_xfer && (item_i.mode == MODE_LOAD) &&
                (32'(item_i.entry_index) == 32'(k));
    msc_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .nxt_code_i (cell_code[(k + 1) % TABLE_DEPTH]),
      .nxt_head_i (cell_head[(k + 1) % TABLE_DEPTH]),
      .wr_i       (wr),
      .wr_code_i  (item_i.code),
      .wr_head_i  (item_i.column_start),
      .code_o     (cell_code[k]),
      .head_o     (cell_head[k])
    );
  end

  msc_probe u_probe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_scan),
    .step_i       (step_active),
    .first_i      (step_q == '0),
    .entry_code_i (cell_code[0]),
    .entry_head_i (cell_head[0]),
    .code_i       (item_code_q),
    .prev_i       (prev_q),
    .probe_o      (probe)
  );

  always_comb begin
    dec_ok     = pend_ok_q;
    dec_reason = pend_reason_q;
    dec_prev   = prev_q;
    if (from_scan_q) begin
      dec_prev = item_code_q;
      if (prev_q == '0) begin
        dec_ok     = 1'b1;
        dec_reason = (probe.code_found && probe.code_head) ? RSN_FIRST_HEAD
                                                           : RSN_FIRST_OTHER;
      end else if ((item_dir_q == DIR_FORWARD) && probe.before_hit) begin
        dec_ok = 1'b1;
        if (probe.code_head) begin
          dec_reason = RSN_FORWARD_OUT;
          dec_prev   = '0;
        end else begin
          dec_reason = RSN_FORWARD;
        end
      end else if (item_dir_q[1] && probe.after_hit) begin
        dec_ok     = 1'b1;
        dec_reason = RSN_RETREAT;
      end else begin
        dec_ok     = 1'b0;
        dec_reason = RSN_OUT_ORDER;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = start_scan ? ST_SCAN : ST_RESP;
      ST_SCAN: if (scan_last) state_d = ST_RESP;
      ST_RESP: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        step_q <= '0;
        if ((item_i.mode == MODE_RESTART) && check_en_q) begin
          prev_q <= '0;
        end
      end else if (shift) begin
        step_q <= step_q + 1'b1;
      end
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
        prev_q      <= dec_prev;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_code_q <= item_i.code;
      item_dir_q  <= item_i.direction;
      from_scan_q <= start_scan;
      case (item_i.mode)
        MODE_CHECK: begin
          pend_ok_q     <= 1'b1;
          pend_reason_q <= check_en_q ? RSN_SAME : RSN_DISABLED;
        end
        MODE_UNUSED: begin
          pend_ok_q     <= 1'b0;
          pend_reason_q <= RSN_ACK;
        end
        default: begin
          pend_ok_q     <= 1'b1;
          pend_reason_q <= RSN_ACK;
        end
      endcase
    end
    if ((state_q == ST_RESP) && out_free) begin
      out_ok_q     <= dec_ok;
      out_reason_q <= dec_reason;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.in_order = out_ok_q;
  assign result_o.reason   = out_reason_q;

endmodule

`default_nettype wire
